/* rtl/sldr_pkg.sv */
`default_nettype none
package sldr_pkg;
    // register indexes
    localparam logic [1:0] REG_MAX_LIN_SPEED = 2'd0;
    localparam logic [1:0] REG_MAX_ANG_SPEED = 2'd1;
    localparam logic [1:0] REG_MAX_LIN_ACCEL = 2'd2;
    localparam logic [1:0] REG_MAX_ANG_ACCEL = 2'd3;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;

    // arctangent table in binary-angle units
    function automatic logic [29:0] atan_bam(input logic [4:0] i);
        case (i)
            5'd0: atan_bam = 30'd536870912;
            5'd1: atan_bam = 30'd316933406;
            5'd2: atan_bam = 30'd167458907;
            5'd3: atan_bam = 30'd85004756;
            5'd4: atan_bam = 30'd42667331;
            5'd5: atan_bam = 30'd21354465;
            5'd6: atan_bam = 30'd10679838;
            5'd7: atan_bam = 30'd5340245;
            5'd8: atan_bam = 30'd2670163;
            5'd9: atan_bam = 30'd1335087;
            5'd10: atan_bam = 30'd667544;
            5'd11: atan_bam = 30'd333772;
            5'd12: atan_bam = 30'd166886;
            5'd13: atan_bam = 30'd83443;
            5'd14: atan_bam = 30'd41722;
            5'd15: atan_bam = 30'd20861;
            5'd16: atan_bam = 30'd10430;
            5'd17: atan_bam = 30'd5215;
            5'd18: atan_bam = 30'd2608;
            5'd19: atan_bam = 30'd1304;
            5'd20: atan_bam = 30'd652;
            5'd21: atan_bam = 30'd326;
            5'd22: atan_bam = 30'd163;
            5'd23: atan_bam = 30'd81;
            default: atan_bam = 30'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

/* rtl/sldr_cordic.sv */
`default_nettype none
// Iterative rotation CORDIC: one micro-rotation per cycle.
module sldr_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic                    done,
    output logic signed [31:0]      cos_q30,
    output logic signed [31:0]      sin_q30
);
    import sldr_pkg::*;

    localparam int NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

    logic               busy_reg;
    logic [4:0]         idx_reg;
    logic               flip_reg;
    logic signed [32:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic signed [32:0] xs, ys;
    logic               flip;
    logic [31:0]        a;

    assign flip = (angle - 32'h4000_0000) < 32'h8000_0000;
    assign a    = flip ? angle - 32'h8000_0000 : angle;
    assign xs   = x_reg >>> idx_reg;
    assign ys   = y_reg >>> idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (idx_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                idx_reg <= idx_reg + 5'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= flip;
            x_reg    <= 33'(CORDIC_GAIN_Q30);
            y_reg    <= '0;
            z_reg    <= 33'($signed(a));
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - $signed({3'b000, atan_bam(idx_reg)});
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + $signed({3'b000, atan_bam(idx_reg)});
            end
        end
    end

    assign cos_q30 = flip_reg ? 32'(-x_reg) : x_reg[31:0];
    assign sin_q30 = flip_reg ? 32'(-y_reg) : y_reg[31:0];
endmodule
`default_nettype wire

/* rtl/slew_limited_dead_reckoning.sv */
`default_nettype none
// Channel  | Dir | Beat contents (low bit first)
// s_axis   | in  | tdata: elapsed_time[15:0], target_linear_speed[39:16],
//          |     |        target_angular_speed[63:40]
// m_axis   | out | tdata: pos_x, pos_y, heading, linear_speed, angular_speed (144b)
// cfg      | in  | cfg_we, cfg_index[1:0], cfg_data[30:0]
// A tick steps through the LSTEP, ASTEP, RAMP, DS, DTH, BAM, YAW, CORD, PX,
// PY and OUT states; no new tick is taken meanwhile. A single shared
// multiplier serves the ramp, turn and position products, then the
// CORDIC iterates. s_axis_tready is high only when idle and the output
// register is empty. Reset returns the pose and speeds to zero and the limits
// to defaults.
module slew_limited_dead_reckoning #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // elapsed_time, target_linear, target_angular
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,   // pos_x, pos_y, heading, lin, ang
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);
    import sldr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_LSTEP = 4'd1, ST_ASTEP = 4'd2,
        ST_RAMP = 4'd3, ST_DS = 4'd4, ST_DTH = 4'd5, ST_BAM = 4'd6,
        ST_YAW = 4'd7, ST_CORD = 4'd8, ST_PX = 4'd9, ST_PY = 4'd10, ST_OUT = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [22:0] max_lin_reg, max_ang_reg;
    logic [30:0] acc_lin_reg, acc_ang_reg;
    logic signed [23:0] cur_lin_reg, cur_ang_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0] yaw_reg;
    logic [15:0] dt_reg;
    logic signed [23:0] tl_reg, ta_reg;
    logic signed [47:0] lstep_reg, astep_reg, ds_reg, dth_reg;
    logic signed [63:0] prod;
    logic signed [32:0] mul_a, mul_b;
    logic        cord_start, cord_done;
    logic signed [31:0] cos_q30, sin_q30;

    // shared signed multiplier
    assign prod = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LSTEP: begin mul_a = 33'($signed({1'b0, acc_lin_reg})); mul_b = 33'($signed({1'b0, dt_reg})); end
            ST_ASTEP: begin mul_a = 33'($signed({1'b0, acc_ang_reg})); mul_b = 33'($signed({1'b0, dt_reg})); end
            ST_DS:    begin mul_a = 33'(cur_lin_reg); mul_b = 33'($signed({1'b0, dt_reg})); end
            ST_DTH:   begin mul_a = 33'(cur_ang_reg); mul_b = 33'($signed({1'b0, dt_reg})); end
            ST_BAM:   begin mul_a = 33'(dth_reg); mul_b = 33'($signed({1'b0, RAD_TO_BAM})); end
            ST_PX:    begin mul_a = 33'(ds_reg); mul_b = 33'(cos_q30); end
            ST_PY:    begin mul_a = 33'(ds_reg); mul_b = 33'(sin_q30); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    function automatic logic signed [23:0] ramp(input logic signed [23:0] cur,
        input logic signed [23:0] tar, input logic [22:0] vmax, input logic signed [47:0] step);
        logic signed [48:0] lim, c, r;
        begin
            c = 49'(cur);
            if (tar > cur)
            begin
                lim = (49'(tar) < 49'($signed({1'b0, vmax}))) ? 49'(tar) : 49'($signed({1'b0, vmax}));
                r = (lim < c + 49'(step)) ? lim : c + 49'(step);
            end
            else if (tar < cur)
            begin
                lim = (49'(tar) > -49'($signed({1'b0, vmax}))) ? 49'(tar) : -49'($signed({1'b0, vmax}));
                r = (lim > c - 49'(step)) ? lim : c - 49'(step);
            end
            else
            begin
                lim = '0;
                r = c;
            end
            ramp = r[23:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] b,
        input logic signed [63:0] d);
        logic signed [64:0] s;
        begin
            s = 65'(b) + 65'(d);
            if (s > 65'sd2147483647) sat_add = 32'h7FFF_FFFF;
            else if (s < -65'sd2147483648) sat_add = 32'h8000_0000;
            else sat_add = s[31:0];
        end
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE) && !m_axis_tvalid;
    assign cord_start    = (state_reg == ST_YAW);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = ST_LSTEP;
            ST_LSTEP: state_next = ST_ASTEP;
            ST_ASTEP: state_next = ST_RAMP;
            ST_RAMP:  state_next = ST_DS;
            ST_DS:    state_next = ST_DTH;
            ST_DTH:   state_next = ST_BAM;
            ST_BAM:   state_next = ST_YAW;
            ST_YAW:   state_next = ST_CORD;
            ST_CORD:  if (cord_done) state_next = ST_PX;
            ST_PX:    state_next = ST_PY;
            ST_PY:    state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_lin_reg   <= 23'd65536;
            max_ang_reg   <= 23'd102892;
            acc_lin_reg   <= 31'd65470464;
            acc_ang_reg   <= 31'd65470464;
            cur_lin_reg   <= '0;
            cur_ang_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            yaw_reg       <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_LIN_SPEED: max_lin_reg <= cfg_data[22:0];
                    REG_MAX_ANG_SPEED: max_ang_reg <= cfg_data[22:0];
                    REG_MAX_LIN_ACCEL: acc_lin_reg <= cfg_data;
                    REG_MAX_ANG_ACCEL: acc_ang_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_RAMP)
            begin
                cur_lin_reg <= ramp(cur_lin_reg, tl_reg, max_lin_reg, lstep_reg);
                cur_ang_reg <= ramp(cur_ang_reg, ta_reg, max_ang_reg, astep_reg);
            end
            if (state_reg == ST_BAM)
                yaw_reg <= yaw_reg + 32'(prod >>> FRAC_BITS);
            if (state_reg == ST_PX)
                x_reg <= sat_add(x_reg, prod >>> 30);
            if (state_reg == ST_PY)
                y_reg <= sat_add(y_reg, prod >>> 30);
            if (state_reg == ST_OUT)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            dt_reg <= s_axis_tdata[15:0];
            tl_reg <= s_axis_tdata[39:16];
            ta_reg <= s_axis_tdata[63:40];
        end
        case (state_reg)
            ST_LSTEP: lstep_reg <= 48'(prod >>> FRAC_BITS);
            ST_ASTEP: astep_reg <= 48'(prod >>> FRAC_BITS);
            ST_DS:    ds_reg    <= 48'(prod >>> FRAC_BITS);
            ST_DTH:   dth_reg   <= 48'(prod >>> FRAC_BITS);
            default: ;
        endcase
    end

    assign m_axis_tdata = {cur_ang_reg, cur_lin_reg, yaw_reg, y_reg, x_reg};

    sldr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (yaw_reg),
        .done    (cord_done),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );
endmodule
`default_nettype wire

/* tb/tb_slew_limited_dead_reckoning.sv */
`default_nettype none
module tb_slew_limited_dead_reckoning;
    import sldr_pkg::*;

    localparam int NSTEPS = 16;
    localparam int FBITS = 16;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;
    localparam longint TURN_SCALE = 64'sd683565276;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint ARCTAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    typedef struct packed {
        logic signed [23:0] tgt_ang;
        logic signed [23:0] tgt_lin;
        logic [15:0] dt;
    } tick_t;

    typedef struct packed {
        logic signed [23:0] ang;
        logic signed [23:0] lin;
        logic [31:0] heading;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [30:0] cfg_data;

    slew_limited_dead_reckoning dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of limits and pose
    longint lim_lin_speed, lim_ang_speed, lim_lin_accel, lim_ang_accel;
    longint pr_lin, pr_ang, pr_x, pr_y;
    logic [31:0] pr_yaw;

    tick_t ticks_pending[$];
    pose_t poses_expected[$];
    int errors = 0;
    int ticks_sent = 0;
    int poses_seen = 0;
    int sat_hits = 0;
    int idle_cycles = 0;
    bit calm = 0;
    bit hold_req = 0;
    bit finishing = 0;
    int hold_cnt = 0;
    bit sender_busy;

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint slew(longint cur, longint tar, longint vmax, longint stp);
        longint r;
        if (tar > cur)
        begin
            r = (tar < vmax) ? tar : vmax;
            if (cur + stp < r) r = cur + stp;
        end
        else if (tar < cur)
        begin
            r = (tar > -vmax) ? tar : -vmax;
            if (cur - stp > r) r = cur - stp;
        end
        else
            r = tar;
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // advance the pose by one tick and return the expected output beat
    function automatic pose_t advance_pose(tick_t t);
        longint dt, ds, dth, turn, xc, ys, zr, xs, yss, cs, sn;
        logic [31:0] a;
        bit flip;
        pose_t p;
        dt = longint'(t.dt);
        pr_lin = slew(pr_lin, longint'(t.tgt_lin), lim_lin_speed,
                      (lim_lin_accel * dt) >>> FBITS);
        pr_ang = slew(pr_ang, longint'(t.tgt_ang), lim_ang_speed,
                      (lim_ang_accel * dt) >>> FBITS);
        ds = (pr_lin * dt) >>> FBITS;
        dth = (pr_ang * dt) >>> FBITS;
        turn = (dth * TURN_SCALE) >>> FBITS;
        pr_yaw = pr_yaw + turn[31:0];
        // rotate the back half-plane by half a turn first
        flip = (pr_yaw - 32'h4000_0000) < 32'h8000_0000;
        a = flip ? pr_yaw - 32'h8000_0000 : pr_yaw;
        zr = longint'($signed(a));
        xc = GAIN_Q30;
        ys = 0;
        for (int i = 0; i < NSTEPS; i++)
        begin
            xs = xc >>> i;
            yss = ys >>> i;
            if (zr >= 0)
            begin
                xc = xc - yss;
                ys = ys + xs;
                zr = zr - ARCTAN[i];
            end
            else
            begin
                xc = xc + yss;
                ys = ys - xs;
                zr = zr + ARCTAN[i];
            end
        end
        cs = flip ? -xc : xc;
        sn = flip ? -ys : ys;
        xs = pr_x + ((ds * cs) >>> 30);
        yss = pr_y + ((ds * sn) >>> 30);
        if (xs != clamp32(xs) || yss != clamp32(yss)) sat_hits++;
        pr_x = clamp32(xs);
        pr_y = clamp32(yss);
        p.x = pr_x[31:0];
        p.y = pr_y[31:0];
        p.heading = pr_yaw;
        p.lin = pr_lin[23:0];
        p.ang = pr_ang[23:0];
        return p;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("beat %0d: %s got %0d expected %0d", poses_seen, what, got, want);
        errors++;
    endtask

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            sender_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                poses_expected.push_back(advance_pose(ticks_pending.pop_front()));
                ticks_sent++;
                sender_busy = 0;
            end
            if (!sender_busy)
            begin
                if (ticks_pending.size() > 0 && (calm || $urandom_range(99) >= 29))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= ticks_pending[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // pose monitor with random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                pose_t got, want;
                got = m_axis_tdata;
                if (poses_expected.size() == 0)
                    report("unexpected pose beat, pos_x", got.x, 0);
                else
                begin
                    want = poses_expected.pop_front();
                    if (got.x != want.x) report("pos_x", got.x, want.x);
                    if (got.y != want.y) report("pos_y", got.y, want.y);
                    if (got.heading != want.heading)
                        report("heading", got.heading, want.heading);
                    if (got.lin != want.lin) report("linear_speed", got.lin, want.lin);
                    if (got.ang != want.ang) report("angular_speed", got.ang, want.ang);
                end
                poses_seen++;
            end
            if (hold_req && hold_cnt == 0)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_cnt > 0) hold_cnt--;
            m_axis_tready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= 29);
        end
    end

    // watchdog on cycles with no beat either way
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || finishing)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("slew_limited_dead_reckoning: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_LIN_SPEED: lim_lin_speed = longint'(val[22:0]);
            REG_MAX_ANG_SPEED: lim_ang_speed = longint'(val[22:0]);
            REG_MAX_LIN_ACCEL: lim_lin_accel = longint'(val);
            REG_MAX_ANG_ACCEL: lim_ang_accel = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [30:0] ls, logic [30:0] as, logic [30:0] la,
                              logic [30:0] aa);
        write_reg(REG_MAX_LIN_SPEED, ls);
        write_reg(REG_MAX_ANG_SPEED, as);
        write_reg(REG_MAX_LIN_ACCEL, la);
        write_reg(REG_MAX_ANG_ACCEL, aa);
    endtask

    task automatic drain();
        while (ticks_pending.size() > 0 || poses_expected.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic push_tick(int dt, int tl, int ta);
        tick_t t;
        t.dt = dt[15:0];
        t.tgt_lin = tl[23:0];
        t.tgt_ang = ta[23:0];
        ticks_pending.push_back(t);
    endtask

    // random tick: mostly full range, sometimes extremes or small steps
    task automatic push_random_ticks(int n);
        int dt, tl, ta;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0: dt = $urandom_range(255);
                1: dt = 65535;
                default: dt = $urandom_range(65535);
            endcase
            case ($urandom_range(4))
                0: tl = ($urandom_range(1)) ? 8388607 : -8388608;
                1: tl = $urandom_range(131072) - 65536;
                default: tl = $urandom();
            endcase
            case ($urandom_range(4))
                0: ta = ($urandom_range(1)) ? 8388607 : -8388608;
                1: ta = $urandom_range(131072) - 65536;
                default: ta = $urandom();
            endcase
            push_tick(dt, tl, ta);
            // repeat a tick now and then so targets get reached and held
            if ($urandom_range(9) == 0) push_tick(dt, tl, ta);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        lim_lin_speed = 65536;
        lim_ang_speed = 102892;
        lim_lin_accel = 65470464;
        lim_ang_accel = 65470464;
        pr_lin = 0;
        pr_ang = 0;
        pr_x = 0;
        pr_y = 0;
        pr_yaw = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset limits: zero dt, extremes, held targets, beyond-limit targets
        push_tick(0, 8388607, -8388608);
        push_tick(65535, 8388607, 8388607);
        push_tick(65535, 8388607, 8388607);
        push_tick(0, 8388607, 8388607);
        push_tick(65535, -8388608, -8388608);
        push_tick(1, -8388608, -8388608);
        push_tick(32768, 65536, 102892);
        push_tick(32768, 65536, 102892);
        push_tick(65535, 0, 0);
        push_tick(65535, 0, 0);
        push_tick(16384, 40000, -50000);
        push_tick(16384, 40000, -50000);
        push_tick(65535, -1, 1);
        push_tick(65535, 12345, 205784);
        push_tick(0, 0, 0);
        push_tick(65535, -65536, -102892);
        push_tick(65535, 70000, 110000);
        push_tick(21845, 5000, -5000);
        drain();

        // widest limits, long idle-free run to push the pose into saturation
        set_limits(31'h007F_FFFF, 31'h007F_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        calm = 1;
        for (int i = 0; i < 150; i++) push_tick(65535, 8388607, 3000);
        push_random_ticks(60);
        drain();
        calm = 0;

        // all limits zero: from a fast state, a speed drops to zero when its target lies beyond it, else holds
        set_limits(31'd0, 31'd0, 31'd0, 31'd0);
        push_random_ticks(30);
        drain();

        // random moderate limits with a long output stall
        set_limits($urandom_range(2000000), $urandom_range(2000000),
                   $urandom(), $urandom());
        push_random_ticks(150);
        hold_req = 1;
        push_random_ticks(130);
        drain();

        // back to the reset values, then random limits again
        set_limits(31'd65536, 31'd102892, 31'd65470464, 31'd65470464);
        push_random_ticks(130);
        drain();
        set_limits($urandom(), $urandom(), $urandom_range(1000000), $urandom());
        push_random_ticks(130);
        drain();

        finishing = 1;
        $display("ran %0d ticks over six limit settings, %0d pose beats checked",
                 ticks_sent, poses_seen);
        $display("position saturation seen on %0d ticks, %0d field errors",
                 sat_hits, errors);
        if (errors == 0)
            $display("slew_limited_dead_reckoning: match");
        else
            $display("slew_limited_dead_reckoning: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/sldr_pkg.sv
rtl/sldr_cordic.sv
rtl/slew_limited_dead_reckoning.sv
tb/tb_slew_limited_dead_reckoning.sv
